@@ rtl/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies; take in with `include "assert_macros.svh"
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is high
`define SBTR_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sbtr assertion failed");

// concurrent check that also runs across reset
`define SBTR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("sbtr assertion failed");

`endif

@@ rtl/sbtr_pkg.sv @@
// types, request and status codes, and state encoding for the boundary table
// no dependencies; used by the cell, top level and checker file of the block
package sbtr_pkg;

  localparam int TIME_W   = 32;
  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 6;
  localparam int USED_W   = 7;
  localparam int COUNT_W8 = 8;
  localparam int MASK_W   = 8;

  // the epoch total saturates here
  localparam logic [COUNT_W8-1:0] COUNT_SAT = 8'd255;

  // request codes
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_RANK   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic [MASK_W-1:0] MASK_RESET = 8'd1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [TIME_W-1:0]  event_time;
    logic [KIND_W-1:0]  entry_kind;
    logic [INDEX_W-1:0] entry_index;
  } req_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [COUNT_W8-1:0] epoch_position;
    logic [USED_W-1:0]   entries_used;
    logic [COUNT_W8-1:0] epoch_total;
  } rsp_item_t;

  // one table entry as held in a cell
  typedef struct packed {
    logic [TIME_W-1:0] time_val;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // command broadcast to every cell
  typedef struct packed {
    logic               ins_en;
    logic               rem_en;
    logic [TIME_W-1:0]  event_time;
    logic [KIND_W-1:0]  entry_kind;
    logic [INDEX_W-1:0] entry_index;
  } cmd_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_APPLY,
    FSM_FLAG,
    FSM_SUM
  } state_t;

endpackage

@@ rtl/sbtr_cell.sv @@
// one cell of the sorted table: holds an entry, shifts with its neighbors
// depends on sbtr_pkg
module sbtr_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5
) (
  input  logic                clk,
  input  sbtr_pkg::cmd_t      cmd,
  input  logic [CNT_W-1:0]    count,
  input  logic [sbtr_pkg::MASK_W-1:0] mask,
  input  sbtr_pkg::entry_t    left_entry,
  input  logic                left_shift,
  input  sbtr_pkg::entry_t    right_entry,
  output sbtr_pkg::entry_t    entry,
  output logic                shift,
  output logic                rank_hit,
  output logic                epoch_hit
);

  localparam int IW = sbtr_pkg::INDEX_W;
  localparam logic [CNT_W-1:0] POS     = CNT_W'(CELL_IDX);
  localparam logic [IW-1:0]    POS_IDX = IW'(CELL_IDX);

  logic occ;
  logic at_end;
  logic kind_marked;
  sbtr_pkg::entry_t entry_next;

  // position of this cell against the fill count
  assign occ         = POS < count;
  assign at_end      = POS == count;
  assign kind_marked = mask[entry.kind];

  // entry moves one place right when the new time sorts before it
  assign shift = occ && (entry.time_val > cmd.event_time);

  // insert takes from the left or the new item, remove takes from the right
  always_comb begin
    entry_next = entry;
    if (cmd.ins_en) begin
      if (left_shift) begin
        entry_next = left_entry;
      end else if (shift || at_end) begin
        entry_next.time_val = cmd.event_time;
        entry_next.kind     = cmd.entry_kind;
      end
    end else if (cmd.rem_en) begin
      if (occ && (cmd.entry_index <= POS_IDX)) begin
        entry_next = right_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

  // per-cell flags for the rank and epoch counts
  always_ff @(posedge clk) begin
    rank_hit  <= occ && kind_marked && (cmd.event_time != '0)
                 && (entry.time_val <= cmd.event_time);
    epoch_hit <= occ && kind_marked;
  end

endmodule

@@ rtl/sorted_boundary_table_rank.sv @@
// top level of the sorted boundary table with rank query
// depends on sbtr_pkg and sbtr_cell
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-----------------------
//   req      | in        | req_valid/stall    | req_item (sbtr_pkg::req_item_t)
//   rsp      | out       | rsp_valid/stall    | rsp_item (sbtr_pkg::rsp_item_t)
//   cfg      | in        | cfg_valid/ready    | cfg_data (epoch kind mask)
//
// an item passes four steps: accept, apply to the cell chain, compare in the
// cells, count the cell flags into the result register
// the count cycle waits while the previous result is still stalled
// reset clears the fill count, the fsm and the result valid; the mask resets to 1
// table entries are not cleared: only entries below the fill count are read
module sorted_boundary_table_rank #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   req_valid,
  output logic                   req_stall,
  input  sbtr_pkg::req_item_t    req_item,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output sbtr_pkg::rsp_item_t    rsp_item,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [sbtr_pkg::MASK_W-1:0] cfg_data
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = sbtr_pkg::INDEX_W + 1;

  sbtr_pkg::state_t state, state_next;
  sbtr_pkg::req_item_t req_q;
  logic [CNT_W-1:0] count, count_next;
  logic [sbtr_pkg::MASK_W-1:0] mask;
  logic [1:0] status, status_next;
  sbtr_pkg::cmd_t cmd;

  sbtr_pkg::entry_t cell_entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_shift;
  logic [MAX_ENTRIES-1:0] rank_hits;
  logic [MAX_ENTRIES-1:0] epoch_hits;

  logic [CNT_W-1:0] rank_cnt;
  logic [CNT_W-1:0] epoch_cnt;
  logic [sbtr_pkg::COUNT_W8-1:0] epoch_cnt8;
  logic req_accept;
  logic rsp_load;
  logic ins_ok;
  logic rem_ok;

  assign req_accept = req_valid && !req_stall;
  assign cfg_ready  = (state == sbtr_pkg::FSM_IDLE);

  // argument checks against the current fill count
  assign ins_ok = (req_q.event_time != '0) && (count < CNT_W'(MAX_ENTRIES));
  assign rem_ok = CMP_W'(req_q.entry_index) < CMP_W'(count);

  // command broadcast to the cells
  always_comb begin
    cmd.ins_en      = (state == sbtr_pkg::FSM_APPLY)
                      && (req_q.req_type == sbtr_pkg::REQ_INSERT) && ins_ok;
    cmd.rem_en      = (state == sbtr_pkg::FSM_APPLY)
                      && (req_q.req_type == sbtr_pkg::REQ_REMOVE) && rem_ok;
    cmd.event_time  = req_q.event_time;
    cmd.entry_kind  = req_q.entry_kind;
    cmd.entry_index = req_q.entry_index;
  end

  // cell chain
  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    sbtr_pkg::entry_t left_e;
    sbtr_pkg::entry_t right_e;
    logic left_s;

    if (g == 0) begin : g_first
      assign left_e = '0;
      assign left_s = 1'b0;
    end else begin : g_mid
      assign left_e = cell_entry[g-1];
      assign left_s = cell_shift[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign right_e = cell_entry[g];
    end else begin : g_inner
      assign right_e = cell_entry[g+1];
    end

    sbtr_cell #(
      .CELL_IDX (g),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .count       (count),
      .mask        (mask),
      .left_entry  (left_e),
      .left_shift  (left_s),
      .right_entry (right_e),
      .entry       (cell_entry[g]),
      .shift       (cell_shift[g]),
      .rank_hit    (rank_hits[g]),
      .epoch_hit   (epoch_hits[g])
    );
  end

  // flag counts
  assign rank_cnt   = CNT_W'($countones(rank_hits));
  assign epoch_cnt  = CNT_W'($countones(epoch_hits));
  assign epoch_cnt8 = sbtr_pkg::COUNT_W8'(epoch_cnt);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sbtr_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state, status, fill count, input stall and result load
  always_comb begin
    state_next  = state;
    status_next = status;
    count_next  = count;
    req_stall   = 1'b1;
    rsp_load    = 1'b0;
    unique case (state)
      sbtr_pkg::FSM_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next = sbtr_pkg::FSM_APPLY;
        end
      end
      sbtr_pkg::FSM_APPLY: begin
        state_next = sbtr_pkg::FSM_FLAG;
        unique case (req_q.req_type)
          sbtr_pkg::REQ_INSERT: begin
            if (req_q.event_time == '0) begin
              status_next = sbtr_pkg::ST_INVALID;
            end else if (!ins_ok) begin
              status_next = sbtr_pkg::ST_FULL;
            end else begin
              status_next = sbtr_pkg::ST_OK;
              count_next  = count + CNT_W'(1);
            end
          end
          sbtr_pkg::REQ_REMOVE: begin
            if (rem_ok) begin
              status_next = sbtr_pkg::ST_OK;
              count_next  = count - CNT_W'(1);
            end else begin
              status_next = sbtr_pkg::ST_INVALID;
            end
          end
          sbtr_pkg::REQ_RANK: begin
            status_next = sbtr_pkg::ST_OK;
          end
          default: begin
            status_next = sbtr_pkg::ST_INVALID;
          end
        endcase
      end
      sbtr_pkg::FSM_FLAG: begin
        state_next = sbtr_pkg::FSM_SUM;
      end
      sbtr_pkg::FSM_SUM: begin
        if (!(rsp_valid && rsp_stall)) begin
          rsp_load   = 1'b1;
          state_next = sbtr_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = sbtr_pkg::FSM_IDLE;
      end
    endcase
  end

  // request register
  always_ff @(posedge clk) begin
    if (req_accept) begin
      req_q <= req_item;
    end
  end

  // fill count and status
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    status <= status_next;
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= sbtr_pkg::MASK_RESET;
    end else if (cfg_valid && cfg_ready) begin
      mask <= cfg_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_item.status         <= status;
      rsp_item.epoch_position <= (req_q.req_type == sbtr_pkg::REQ_RANK)
                                 ? sbtr_pkg::COUNT_W8'(rank_cnt) : '0;
      rsp_item.entries_used   <= sbtr_pkg::USED_W'(count);
      rsp_item.epoch_total    <= (epoch_cnt8 >= sbtr_pkg::COUNT_SAT)
                                 ? sbtr_pkg::COUNT_SAT
                                 : epoch_cnt8 + sbtr_pkg::COUNT_W8'(1);
    end
  end

endmodule

@@ rtl/sbtr_check.sv @@
// port-level checks for the boundary table, bound to the top level
// depends on sbtr_pkg and assert_macros.svh
`include "assert_macros.svh"

module sbtr_check #(
  parameter int MAX_ENTRIES = 16
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_stall,
  input logic                   rsp_valid,
  input logic                   rsp_stall,
  input sbtr_pkg::rsp_item_t    rsp_item
);

  // a stalled result holds
  `SBTR_ASSERT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))

  // one item at a time: an accepted item blocks the input next cycle
  `SBTR_ASSERT(a_one_item, clk, rst, req_valid && !req_stall |=> req_stall)

  // fill count stays within the table
  `SBTR_ASSERT(a_used_range, clk, rst, rsp_valid |-> rsp_item.entries_used <= MAX_ENTRIES)

  // a rank never reaches the epoch total
  `SBTR_ASSERT(a_rank_below, clk, rst, rsp_valid |-> rsp_item.epoch_position < rsp_item.epoch_total)

  // no result straight out of reset
  `SBTR_ASSERT_ALWAYS(a_rst_clear, clk, $past(rst) |-> !rsp_valid)

endmodule

bind sorted_boundary_table_rank sbtr_check #(.MAX_ENTRIES(MAX_ENTRIES)) u_sbtr_check (.*);
